/* rtl/core/nes_pkg.sv */
// Shared types and constants for the next event scheduler.
package nes_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned NUM_SRC   = 6;
  localparam int unsigned NUM_EN    = 4;
  localparam int unsigned SRC_W     = 3;
  localparam int unsigned NUM_PAIR  = NUM_SRC / 2;

  localparam logic [SRC_W-1:0] SRC_RENDER = 3'd0;
  localparam logic [SRC_W-1:0] SRC_VDP    = 3'd1;
  localparam logic [SRC_W-1:0] SRC_SCREEN = 3'd2;
  localparam logic [SRC_W-1:0] SRC_DEBUG  = 3'd3;
  localparam logic [SRC_W-1:0] SRC_AUDIO2 = 3'd4;
  localparam logic [SRC_W-1:0] SRC_AUDIO  = 3'd5;

  localparam logic OP_SCHED  = 1'b0;
  localparam logic OP_CPU_EN = 1'b1;

  localparam logic [TIME_BITS-1:0] TIME_SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

  // Commands from the controller to the datapath, at most one per cycle.
  typedef struct packed {
    logic load;
    logic offs;
    logic pair;
    logic pick;
  } nes_cmd_t;

endpackage

/* rtl/core/nes_ctrl.sv */
// Controller state machine that sequences one word through the datapath.
module nes_ctrl
  import nes_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output nes_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFFS,
    ST_PAIR,
    ST_PICK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  // The output register can take a new result when empty or being drained.
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_OFFS;
        end
      end
      ST_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = ST_PAIR;
      end
      ST_PAIR: begin
        cmd_o.pair = 1'b1;
        state_d    = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) begin
          cmd_o.pick  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.load, cmd_o.offs, cmd_o.pair, cmd_o.pick}) <= 1)
    else $error("more than one datapath command in a cycle");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_OFFS))
    else $error("accepted word did not start the offset step");

  a_pick_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pick |-> (!out_valid_q || !out_stall_i))
    else $error("result written over an unread word");

  a_pick_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pick |=> out_valid_q)
    else $error("written result not presented");

endmodule

/* rtl/core/nes_dp.sv */
// Datapath: deadline state, offset registers, pairwise and final selection.
module nes_dp
  import nes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nes_cmd_t         cmd_i,
  input  logic             op_i,
  input  logic [SRC_W-1:0] source_i,
  input  logic             enable_i,
  input  logic [31:0]      event_time_i,
  input  logic [31:0]      now_i,
  output logic [31:0]      next_time_o,
  output logic [SRC_W-1:0] next_source_o
);

  logic [TIME_BITS-1:0] dl_q [NUM_SRC];
  logic [NUM_EN-1:0]    en_q;
  logic                 cpu_en_q;
  logic [TIME_BITS-1:0] now_q;

  logic [TIME_BITS-1:0] off_q  [NUM_SRC];
  logic [NUM_SRC-1:0]   cand_q;

  logic [TIME_BITS-1:0] po_q [NUM_PAIR];
  logic [TIME_BITS-1:0] pt_q [NUM_PAIR];
  logic [SRC_W-1:0]     ps_q [NUM_PAIR];
  logic [NUM_PAIR-1:0]  pv_q;

  logic [TIME_BITS-1:0] next_time_q;
  logic [SRC_W-1:0]     next_src_q;

  logic [TIME_BITS-1:0] etime;
  logic [TIME_BITS-1:0] now_t;
  logic [NUM_SRC-1:0]   cand;

  // Winner of pair 0 against pair 1, then against pair 2.
  logic                 w01_take1;
  logic [TIME_BITS-1:0] w01_off;
  logic [TIME_BITS-1:0] w01_time;
  logic [SRC_W-1:0]     w01_src;
  logic                 w01_valid;
  logic                 take2;

  assign etime = TIME_BITS'(event_time_i);
  assign now_t = TIME_BITS'(now_i);

  // Render and audio always compete; vdp also needs the cpu interrupt enable.
  assign cand = {1'b1, en_q[NUM_EN-1:1], en_q[0] && cpu_en_q, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SRC; i++) begin
        dl_q[i] <= '0;
      end
      en_q     <= NUM_EN'(1);
      cpu_en_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (op_i == OP_CPU_EN) begin
        cpu_en_q <= enable_i;
        if (enable_i && (dl_q[SRC_VDP] <= now_t)) begin
          dl_q[SRC_VDP] <= now_t + TIME_BITS'(1);
        end
      end else begin
        for (int i = 0; i < NUM_SRC; i++) begin
          if (source_i == SRC_W'(i)) begin
            dl_q[i] <= etime;
          end
        end
        for (int i = 0; i < NUM_EN; i++) begin
          if (source_i == SRC_W'(i + 1)) begin
            en_q[i] <= enable_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= now_t;
    end
    // Flipping the sign bit makes unsigned order match signed offset order.
    if (cmd_i.offs) begin
      for (int i = 0; i < NUM_SRC; i++) begin
        off_q[i] <= (dl_q[i] - now_q) ^ TIME_SIGN;
      end
      cand_q <= cand;
    end
    if (cmd_i.pair) begin
      for (int p = 0; p < NUM_PAIR; p++) begin
        if (cand_q[2*p+1] && (!cand_q[2*p] || (off_q[2*p+1] < off_q[2*p]))) begin
          po_q[p] <= off_q[2*p+1];
          pt_q[p] <= dl_q[2*p+1];
          ps_q[p] <= SRC_W'(2*p+1);
        end else begin
          po_q[p] <= off_q[2*p];
          pt_q[p] <= dl_q[2*p];
          ps_q[p] <= SRC_W'(2*p);
        end
        pv_q[p] <= cand_q[2*p] || cand_q[2*p+1];
      end
    end
    if (cmd_i.pick) begin
      next_time_q <= take2 ? pt_q[2] : w01_time;
      next_src_q  <= take2 ? ps_q[2] : w01_src;
    end
  end

  // A later source wins only with a strictly smaller offset.
  assign w01_take1 = pv_q[1] && (!pv_q[0] || (po_q[1] < po_q[0]));
  assign w01_off   = w01_take1 ? po_q[1] : po_q[0];
  assign w01_time  = w01_take1 ? pt_q[1] : pt_q[0];
  assign w01_src   = w01_take1 ? ps_q[1] : ps_q[0];
  assign w01_valid = pv_q[0] || pv_q[1];
  assign take2     = pv_q[2] && (!w01_valid || (po_q[2] < w01_off));

  assign next_time_o   = 32'(next_time_q);
  assign next_source_o = next_src_q;

endmodule

/* rtl/core/next_event_scheduler.sv */
// A word accepted in idle is stepped by the controller through state update, offset,
// pair compare and final compare into the output register, the last step waiting
// while an unread result is stalled; no new word is accepted until it is back in idle.
// A new word may be accepted while the previous result waits at the output.
// Reset clears all deadlines, sets only the vdp enable and clears the cpu
// interrupt enable; no result is valid after reset.
module next_event_scheduler
  import nes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [SRC_W-1:0] source_i,
  input  logic             enable_i,
  input  logic [31:0]      event_time_i,
  input  logic [31:0]      now_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      next_time_o,
  output logic [SRC_W-1:0] next_source_o
);

  nes_cmd_t cmd;

  nes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  nes_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_i),
    .source_i      (source_i),
    .enable_i      (enable_i),
    .event_time_i  (event_time_i),
    .now_i         (now_i),
    .next_time_o   (next_time_o),
    .next_source_o (next_source_o)
  );

endmodule
